FILE: src/assert_macros.svh
// Assertion helpers for the RTL files; the parser core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds on any rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: src/bertlv_pkg.sv
package bertlv_pkg;

  localparam int LEN_WIDTH_DEF = 16;

  // Tag byte whose low five bits are all ones announces further tag bytes.
  localparam logic [4:0] TAG_EXT_CODE = 5'h1F;
  localparam int         TAG_MAX_BYTES = 4;

  // Long length forms: 0x81 to 0x84 give one to four length bytes.
  localparam logic [7:0] LEN_LONG_MIN = 8'h81;
  localparam logic [7:0] LEN_LONG_MAX = 8'h84;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_TAG_LONG = 3'd2,
    ST_TAG_ZERO = 3'd3,
    ST_BAD_LEN  = 3'd4,
    ST_OVER     = 3'd5
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] tag;
    logic [2:0]  tag_bytes;
    logic [31:0] value_length;
    logic [3:0]  header_bytes;
  } res_t;

endpackage

FILE: src/bertlv_parse.sv
module bertlv_parse #(
  parameter int LEN_WIDTH = bertlv_pkg::LEN_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              start_req,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       buffer_len,
  output logic              res_valid,
  output bertlv_pkg::res_t  res
);
  import bertlv_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG_FIRST,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_MORE
  } phase_t;

  phase_t                 phase, phase_next;
  logic [31:0]            tag_acc, tag_acc_next;
  logic [2:0]             tag_count, tag_count_next;
  logic [31:0]            len_acc, len_acc_next;
  logic [2:0]             len_left, len_left_next;
  logic [LEN_WIDTH-1:0]   remaining, remaining_next;
  logic [3:0]             header_count, header_count_next;

  logic [31:0]            blen_ext;
  logic [LEN_WIDTH-1:0]   rem_load;
  logic [31:0]            rem_ext;
  logic                   run;
  logic                   done;
  logic                   give;
  status_t                give_st;

  assign blen_ext = {16'b0, buffer_len};
  assign rem_load = blen_ext[LEN_WIDTH-1:0];

  always_comb begin
    rem_ext = '0;
    rem_ext[LEN_WIDTH-1:0] = remaining_next;
  end

  always_comb begin
    phase_next        = phase;
    tag_acc_next      = tag_acc;
    tag_count_next    = tag_count;
    len_acc_next      = len_acc;
    len_left_next     = len_left;
    remaining_next    = remaining;
    header_count_next = header_count;
    run     = 1'b0;
    done    = 1'b0;
    give    = 1'b0;
    give_st = ST_OK;

    if (accept) begin
      if (start_req) begin
        // A start byte always opens a new buffer, dropping any parse in progress.
        tag_acc_next      = '0;
        tag_count_next    = '0;
        len_acc_next      = '0;
        len_left_next     = '0;
        header_count_next = '0;
        remaining_next    = rem_load;
        if (rem_load == '0) begin
          give    = 1'b1;
          give_st = ST_TRUNC;
        end else begin
          phase_next = PH_TAG_FIRST;
          run        = 1'b1;
        end
      end else if (phase != PH_IDLE) begin
        run = 1'b1;
      end

      if (run) begin
        if (remaining_next != '0) begin
          remaining_next = remaining_next - 1'b1;
        end
        header_count_next = header_count_next + 4'd1;

        case (phase_next)
          PH_TAG_FIRST: begin
            tag_acc_next   = {24'b0, data_byte};
            tag_count_next = 3'd1;
            if (data_byte[4:0] == TAG_EXT_CODE) begin
              phase_next = PH_TAG_MORE;
            end else if (data_byte == 8'h00) begin
              give    = 1'b1;
              give_st = ST_TAG_ZERO;
            end else begin
              phase_next = PH_LEN_FIRST;
            end
          end
          PH_TAG_MORE: begin
            tag_acc_next   = {tag_acc_next[23:0], data_byte};
            tag_count_next = tag_count_next + 3'd1;
            if (data_byte[7]) begin
              if (tag_count_next >= 3'(TAG_MAX_BYTES)) begin
                give    = 1'b1;
                give_st = ST_TAG_LONG;
              end
            end else begin
              phase_next = PH_LEN_FIRST;
            end
          end
          PH_LEN_FIRST: begin
            if (data_byte >= LEN_LONG_MIN && data_byte <= LEN_LONG_MAX) begin
              // The low three bits of a long form give the count of length bytes.
              len_left_next = data_byte[2:0];
              phase_next    = PH_LEN_MORE;
            end else if (data_byte[7]) begin
              give    = 1'b1;
              give_st = ST_BAD_LEN;
            end else begin
              len_acc_next = {24'b0, data_byte};
              done         = 1'b1;
            end
          end
          PH_LEN_MORE: begin
            len_acc_next = {len_acc_next[23:0], data_byte};
            if (len_left_next != '0) begin
              len_left_next = len_left_next - 3'd1;
            end
            if (len_left_next == '0) begin
              done = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (!give) begin
          if (done) begin
            give    = 1'b1;
            give_st = (len_acc_next > rem_ext) ? ST_OVER : ST_OK;
          end else if (remaining_next == '0) begin
            give    = 1'b1;
            give_st = ST_TRUNC;
          end
        end
      end

      if (give) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tag_acc      <= '0;
      tag_count    <= '0;
      len_acc      <= '0;
      len_left     <= '0;
      remaining    <= '0;
      header_count <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      tag_acc      <= tag_acc_next;
      tag_count    <= tag_count_next;
      len_acc      <= len_acc_next;
      len_left     <= len_left_next;
      remaining    <= remaining_next;
      header_count <= header_count_next;
    end
  end

  assign res_valid        = give;
  assign res.status       = give_st;
  assign res.tag          = tag_acc_next;
  assign res.tag_bytes    = tag_count_next;
  assign res.value_length = len_acc_next;
  assign res.header_bytes = header_count_next;

endmodule

FILE: src/ber_tlv_header_parser_core.sv
// BER-TLV header parser.
// The input channel (in_valid, in_stall) carries one buffer byte per transfer.
// The first byte of a buffer comes with start_req high and buffer_len holding
// the total byte count; a start byte in the middle of a header restarts the parse.
// The output channel (out_valid, out_stall) carries at most one result per buffer: the
// tag, its byte count, the decoded value length, the header size and a status.
// It appears once the header is complete or at the first error; value bytes
// that follow produce nothing.
// Throughput is one byte per cycle while in_stall is low: the whole per-byte
// state update is a single pass of logic into the parse registers. A result is
// registered from the byte that ends the header and waits behind any earlier one.
// A two-entry output buffer lets bytes keep flowing while a result waits;
// in_stall rises only when both entries are full, so a stalled receiver holds
// back the input from the second pending result onwards.
// Reset (rst, synchronous) returns the parser to waiting for a start byte and
// empties the output buffer.
module ber_tlv_header_parser_core #(
  parameter int LEN_WIDTH = bertlv_pkg::LEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        start_req,
  input  logic [7:0]  data_byte,
  input  logic [15:0] buffer_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] tag,
  output logic [2:0]  tag_bytes,
  output logic [31:0] value_length,
  output logic [3:0]  header_bytes
);
  import bertlv_pkg::*;

`include "assert_macros.svh"

  logic accept;
  logic take;
  logic res_valid;
  res_t res;
  res_t out_r;
  res_t skid_r;
  logic skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  bertlv_parse #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .start_req (start_req),
    .data_byte (data_byte),
    .buffer_len(buffer_len),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_r      <= skid_r;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || take) begin
        out_r     <= res;
        out_valid <= 1'b1;
      end else begin
        skid_r     <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign status       = out_r.status;
  assign tag          = out_r.tag;
  assign tag_bytes    = out_r.tag_bytes;
  assign value_length = out_r.value_length;
  assign header_bytes = out_r.header_bytes;

  `ASSERT_CLK(a_skid_behind_out, clk, rst, skid_valid |-> out_valid, "skid full, output empty")
  `ASSERT_NEVER(a_no_result_when_full, clk, rst, res_valid && skid_valid, "result lost")
  `ASSERT_NEVER(a_skid_fill, clk, rst, $rose(skid_valid) && !$past(out_stall), "bad skid fill")
  `ASSERT_CLK(a_skid_holds, clk, rst, (skid_valid && out_stall) |=> skid_valid, "skid drained early")

endmodule

FILE: tb/bertlv_result_checker.sv
module bertlv_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        start_req,
  input  logic [7:0]  data_byte,
  input  logic [15:0] buffer_len,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [31:0] tag,
  input  logic [2:0]  tag_bytes,
  input  logic [31:0] value_length,
  input  logic [3:0]  header_bytes,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bertlv_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG_FIRST,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_MORE
  } parse_phase_t;

  parse_phase_t ph;
  logic [31:0]  tag_acc;
  logic [2:0]   tag_cnt;
  logic [31:0]  len_acc;
  logic [2:0]   len_left;
  logic [LEN_WIDTH_DEF-1:0] remaining;
  logic [3:0]   hdr_cnt;

  res_t expected_headers[$];

  function automatic void note_failure(input string msg);
    if (fail_count < 10)
      $display("%0t: %s", $realtime, msg);
    fail_count++;
  endfunction

  // Advances the header parse by one byte and says whether it completes a result.
  task automatic parse_byte(input logic first, input logic [7:0] b,
                            input logic [15:0] blen, output logic emit,
                            output res_t r);
    logic    done;
    status_t st;
    done = 1'b0;
    emit = 1'b0;
    st   = ST_OK;
    r    = '0;
    if (first) begin
      tag_acc   = '0;
      tag_cnt   = '0;
      len_acc   = '0;
      len_left  = '0;
      hdr_cnt   = '0;
      remaining = blen[LEN_WIDTH_DEF-1:0];
      if (remaining == '0) begin
        emit = 1'b1;
        st   = ST_TRUNC;
      end else begin
        ph = PH_TAG_FIRST;
      end
    end
    if (!emit && ph != PH_IDLE) begin
      if (remaining != '0)
        remaining--;
      hdr_cnt = hdr_cnt + 4'd1;
      case (ph)
        PH_TAG_FIRST: begin
          tag_acc = {24'd0, b};
          tag_cnt = 3'd1;
          if (b[4:0] == TAG_EXT_CODE)
            ph = PH_TAG_MORE;
          else if (b == 8'h00) begin
            emit = 1'b1;
            st   = ST_TAG_ZERO;
          end else
            ph = PH_LEN_FIRST;
        end
        PH_TAG_MORE: begin
          tag_acc = {tag_acc[23:0], b};
          tag_cnt++;
          if (!b[7])
            ph = PH_LEN_FIRST;
          else if (tag_cnt >= TAG_MAX_BYTES) begin
            emit = 1'b1;
            st   = ST_TAG_LONG;
          end
        end
        PH_LEN_FIRST: begin
          if (b >= LEN_LONG_MIN && b <= LEN_LONG_MAX) begin
            len_left = 3'(b - LEN_LONG_MIN) + 3'd1;
            ph       = PH_LEN_MORE;
          end else if (b[7]) begin
            emit = 1'b1;
            st   = ST_BAD_LEN;
          end else begin
            len_acc = {24'd0, b};
            done    = 1'b1;
          end
        end
        default: begin
          len_acc = {len_acc[23:0], b};
          if (len_left != '0)
            len_left--;
          done = (len_left == '0);
        end
      endcase
      // The length is checked against what is left once the header is consumed.
      if (!emit && done) begin
        emit = 1'b1;
        st   = (len_acc > 32'(remaining)) ? ST_OVER : ST_OK;
      end else if (!emit && remaining == '0) begin
        emit = 1'b1;
        st   = ST_TRUNC;
      end
    end
    if (emit) begin
      r.status       = st;
      r.tag          = tag_acc;
      r.tag_bytes    = tag_cnt;
      r.value_length = len_acc;
      r.header_bytes = hdr_cnt;
      ph             = PH_IDLE;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t fresh;
    logic emit;
    if (rst) begin
      expected_headers.delete();
      ph         = PH_IDLE;
      tag_acc    = '0;
      tag_cnt    = '0;
      len_acc    = '0;
      len_left   = '0;
      remaining  = '0;
      hdr_cnt    = '0;
      fail_count = 0;
      pending   <= 0;
    end else begin
      // Results leave only after the byte that ends their header, so compare first.
      if (out_valid && !out_stall) begin
        if (expected_headers.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d tag %h value_length %h",
                                 status, tag, value_length));
        end else begin
          want = expected_headers.pop_front();
          if (status != want.status || tag != want.tag || tag_bytes != want.tag_bytes ||
              value_length != want.value_length || header_bytes != want.header_bytes)
            note_failure($sformatf({"mismatch: expected status %0d tag %h tag_bytes %0d ",
                                    "value_length %h header_bytes %0d, got status %0d ",
                                    "tag %h tag_bytes %0d value_length %h header_bytes %0d"},
                                   want.status, want.tag, want.tag_bytes,
                                   want.value_length, want.header_bytes, status, tag,
                                   tag_bytes, value_length, header_bytes));
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(start_req, data_byte, buffer_len, emit, fresh);
        if (emit)
          expected_headers.push_back(fresh);
      end
      pending <= expected_headers.size();
    end
  end

endmodule

FILE: tb/tb_ber_tlv_header_parser_core.sv
module tb_ber_tlv_header_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bertlv_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG
  } stall_mode_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        start_req  = 1'b0;
  logic [7:0]  data_byte  = '0;
  logic [15:0] buffer_len = '0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  status;
  logic [31:0] tag;
  logic [2:0]  tag_bytes;
  logic [31:0] value_length;
  logic [3:0]  header_bytes;
  int          fail_count;
  int          pending;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          burst_left = 0;
  logic [7:0]  buf_q[$];

  ber_tlv_header_parser_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_req    (start_req),
    .data_byte    (data_byte),
    .buffer_len   (buffer_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .tag          (tag),
    .tag_bytes    (tag_bytes),
    .value_length (value_length),
    .header_bytes (header_bytes)
  );

  bertlv_result_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_req    (start_req),
    .data_byte    (data_byte),
    .buffer_len   (buffer_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .tag          (tag),
    .tag_bytes    (tag_bytes),
    .value_length (value_length),
    .header_bytes (header_bytes),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #5 clk = ~clk;

  // The receiver moves between never stalling, stalling at random and long stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 2));
      stall_left <= $urandom_range(40, 250);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
      default:      if ($urandom_range(0, 9) == 0) out_stall <= ~out_stall;
    endcase
  end

  // One byte transfer; the sender may idle for a while between bursts.
  task automatic send_byte(input logic first, input logic [7:0] b, input logic [15:0] blen);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    start_req  <= first;
    data_byte  <= b;
    buffer_len <= blen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Sends the first n bytes of buf_q as one buffer; only the first carries the length.
  task automatic send_buffer(input logic [15:0] blen, input int n);
    for (int i = 0; i < n; i++)
      send_byte(i == 0, buf_q[i], (i == 0) ? blen : 16'($urandom));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_buffer(inout int parsed);
    int          kind;
    int          ntag;
    int          nlen;
    int          hdr;
    int          nsend;
    int          extra;
    longint      total;
    logic [31:0] vlen;
    logic [15:0] blen;
    logic [7:0]  b;
    buf_q.delete();
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      // Loose bytes, some of them with a stray start flag.
      nsend = $urandom_range(1, 6);
      repeat (nsend)
        send_byte($urandom_range(0, 3) == 0, 8'($urandom), 16'($urandom));
      parsed += nsend;
      return;
    end
    ntag = (kind == 2) ? 4 : (kind == 1) ? 1 : $urandom_range(1, 4);
    b = 8'($urandom);
    if (ntag == 1) begin
      if (b[4:0] == TAG_EXT_CODE)
        b[4] = 1'b0;
      if (kind == 1)
        b = 8'h00;
    end else begin
      b[4:0] = TAG_EXT_CODE;
    end
    buf_q.push_back(b);
    for (int i = 2; i <= ntag; i++) begin
      b = 8'($urandom);
      // A set top bit on the fourth tag byte asks for a fifth, which is too long.
      b[7] = (i < ntag) || (kind == 2 && $urandom_range(0, 1) == 1);
      buf_q.push_back(b);
    end
    nlen = $urandom_range(0, 4);
    vlen = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 6));
    if (nlen == 0) begin
      vlen = vlen & 32'h7F;
      buf_q.push_back(vlen[7:0]);
    end else begin
      if (nlen < 4)
        vlen = vlen & ((32'd1 << (8 * nlen)) - 32'd1);
      buf_q.push_back(LEN_LONG_MIN + 8'(nlen - 1));
      for (int i = nlen - 1; i >= 0; i--)
        buf_q.push_back(vlen[8*i +: 8]);
    end
    if (kind == 3)
      buf_q[ntag] = ($urandom_range(0, 3) == 0) ? 8'h80 : 8'($urandom_range(133, 255));
    hdr   = buf_q.size();
    total = longint'(hdr) + longint'(vlen);
    case ($urandom_range(0, 4))
      0: total = total;
      1: total = total + $urandom_range(1, 40);
      2: total = total - 1;
      3: total = $urandom_range(1, hdr);
      default: total = $urandom_range(1, 65535);
    endcase
    if (total < 1 || total > 65535)
      total = ($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(1, 65535);
    blen = (kind == 4) ? 16'd0 : 16'(total);
    nsend = hdr;
    if (kind == 5) begin
      // The next buffer's start byte cuts into this header.
      nsend = $urandom_range(1, hdr);
    end else begin
      extra = $urandom_range(0, 3);
      repeat (extra) buf_q.push_back(8'($urandom));
      nsend = buf_q.size();
    end
    parsed += nsend;
    send_buffer(blen, nsend);
  endtask

  initial begin
    int  parsed;
    bit  paused;
    parsed = 0;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(1'b0, 8'h33, 16'hFFFF);      // byte while idle, no start
    buf_q = '{8'h5A};
    send_buffer(16'h0000, 1);              // empty buffer
    buf_q = '{8'h00};
    send_buffer(16'd5, 1);                 // zero tag
    buf_q = '{8'h5A, 8'h00};
    send_buffer(16'd2, 2);                 // empty value that fits exactly
    buf_q = '{8'h9F, 8'h81, 8'h82, 8'hFF};
    send_buffer(16'd10, 4);                // tag runs past four bytes
    buf_q = '{8'hDF, 8'hFF, 8'hFF, 8'h7F, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buffer(16'hFFFF, 9);              // longest header, length compared unsigned
    buf_q = '{8'h01, 8'h80};
    send_buffer(16'd4, 2);                 // indefinite length form is refused
    buf_q = '{8'h1F};
    send_buffer(16'd1, 1);                 // buffer ends inside the tag
    buf_q = '{8'h9F};
    send_buffer(16'd6, 1);                 // dropped by the restart below
    buf_q = '{8'h02, 8'h01, 8'hAA};
    send_buffer(16'd3, 3);
    wait_for_results();

    while (parsed < 480) begin
      if (!paused && parsed >= 240) begin
        wait_for_results();
        paused = 1'b1;
      end
      random_buffer(parsed);
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_ber_tlv_header_parser_core passed");
    else
      $display("tb_ber_tlv_header_parser_core failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_ber_tlv_header_parser_core failed");
    $finish;
  end

endmodule
